FILE: design/ordered_list_insert_delete_search_macros.svh
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define OLIDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list check failed");

// Antecedent implies consequent in the next cycle.
`define OLIDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list check failed");

`else

`define OLIDS_ASSERT_IMP(label, clk, rst, ante, cons)
`define OLIDS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/olids_pkg.sv
package olids_pkg;

   localparam int DEPTH     = 128;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths on the ports
   localparam int MODE_W    = 2;
   localparam int KEY_IN_W  = 32;
   localparam int DATA_IN_W = 32;
   localparam int POS_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int FOUND_W   = 7;
   localparam int ECNT_W    = 8;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Two-level priority encoder for search hits
   localparam int PRIO_GROUP  = 8;
   localparam int PRIO_GROUPS = (DEPTH + PRIO_GROUP - 1) / PRIO_GROUP;
   localparam int PRIO_PAD_W  = PRIO_GROUPS * PRIO_GROUP;
   localparam int PRIO_SUB_W  = $clog2(PRIO_GROUP);
   localparam int PRIO_FULL_W = $clog2(PRIO_PAD_W);

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND,
      MODE_INSERT,
      MODE_SEARCH,
      MODE_DELETE
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_BAD_POS   = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_GRP,
      ST_FIN
   } state_type;

   typedef struct packed {
      mode_type              mode;
      logic [KEY_IN_W-1:0]   key;
      logic [DATA_IN_W-1:0]  payload;
      logic [POS_W-1:0]      position;
   } olids_req_type;

   typedef struct packed {
      status_type            status;
      logic [FOUND_W-1:0]    found_position;
      logic [ECNT_W-1:0]     entry_count;
   } olids_rsp_type;

   // Broadcast to every cell
   typedef struct packed {
      logic                  load_en;
      mode_type              mode;
      logic [CNT_W-1:0]      pos;
      logic [CNT_W-1:0]      count;
   } olids_cmd_type;

   typedef struct packed {
      logic                  hit;
      logic [IDX_W-1:0]      idx;
   } olids_find_type;

endpackage

FILE: design/ordered_list_insert_delete_search.sv
// Ordered list of up to DEPTH key/payload entries held in a row of cells. Append, insert
// and delete move every entry at once and their result is registered in the next cycle, so
// such requests are taken one per cycle while the result side keeps up; a search on an empty
// list is answered the same way. A search on a non-empty list steps through ST_CMP, ST_GRP
// and ST_FIN: the cells compare their keys in parallel, then a two-level registered priority
// encoder picks the lowest matching position, and no new request is taken until that result
// is loaded. Every result reports the status and the entry count after the operation.
`include "ordered_list_insert_delete_search_macros.svh"

module ordered_list_insert_delete_search
   import olids_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  olids_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output olids_rsp_type rsp_data
);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [KEY_BITS-1:0]   skey_ff, skey_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   olids_rsp_type         rsp_ff, rsp_in;
   logic                  rsp_load;
   logic                  accept;
   status_type            op_status;
   logic                  search_go;
   logic [CMP_W-1:0]      pos_c, cnt_c;
   logic                  full;
   olids_cmd_type         cmd;
   olids_find_type        find;
   logic [KEY_BITS-1:0]   new_key;
   logic [DATA_BITS-1:0]  new_data;
   logic [KEY_BITS-1:0]   cell_key  [DEPTH];
   logic [DATA_BITS-1:0]  cell_data [DEPTH];
   logic [DEPTH-1:0]      match_vec;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign pos_c    = CMP_W'(req_data.position);
   assign cnt_c    = CMP_W'(count_ff);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign new_key  = KEY_BITS'(req_data.key);
   assign new_data = DATA_BITS'(req_data.payload);

   always_comb begin
      op_status = STATUS_OK;
      unique case (req_data.mode)
         MODE_APPEND: begin
            if (full) op_status = STATUS_FULL;
         end
         MODE_INSERT: begin
            if (full) op_status = STATUS_FULL;
            else if (pos_c > cnt_c) op_status = STATUS_BAD_POS;
         end
         MODE_SEARCH: begin
            if (count_ff == '0) op_status = STATUS_EMPTY;
         end
         MODE_DELETE: begin
            if (count_ff == '0) op_status = STATUS_EMPTY;
            else if (pos_c >= cnt_c) op_status = STATUS_BAD_POS;
         end
      endcase
   end

   assign search_go = accept && (req_data.mode == MODE_SEARCH) && (op_status == STATUS_OK);

   always_comb begin
      cmd.load_en = accept && (op_status == STATUS_OK) && (req_data.mode != MODE_SEARCH);
      cmd.mode    = req_data.mode;
      // append is an insert at the current count
      cmd.pos     = (req_data.mode == MODE_APPEND) ? count_ff : CNT_W'(req_data.position);
      cmd.count   = count_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load_en) begin
         if (req_data.mode == MODE_DELETE) count_in = count_ff - CNT_W'(1);
         else                              count_in = count_ff + CNT_W'(1);
      end
   end

   assign skey_in = accept ? new_key : skey_ff;

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]  lk, rk;
      logic [DATA_BITS-1:0] ld, rd;
      if (i == 0) begin : g_first
         assign lk = '0;
         assign ld = '0;
      end else begin : g_left
         assign lk = cell_key[i-1];
         assign ld = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rk = '0;
         assign rd = '0;
      end else begin : g_right
         assign rk = cell_key[i+1];
         assign rd = cell_data[i+1];
      end
      olids_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .new_key    (new_key),
         .new_data   (new_data),
         .left_key   (lk),
         .left_data  (ld),
         .right_key  (rk),
         .right_data (rd),
         .search_key (skey_ff),
         .key        (cell_key[i]),
         .data       (cell_data[i]),
         .match      (match_vec[i])
      );
   end

   olids_prio u_prio (
      .clock     (clock),
      .match_vec (match_vec),
      .find      (find)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (search_go) state_in = ST_CMP;
         ST_CMP:  state_in = ST_GRP;
         ST_GRP:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !search_go) begin
               rsp_load              = 1'b1;
               rsp_in.status         = op_status;
               rsp_in.found_position = '0;
               rsp_in.entry_count    = ECNT_W'(count_in);
            end
         end
         ST_FIN: begin
            rsp_load              = 1'b1;
            rsp_in.status         = find.hit ? STATUS_OK : STATUS_NOT_FOUND;
            rsp_in.found_position = find.hit ? FOUND_W'(find.idx) : '0;
            rsp_in.entry_count    = ECNT_W'(count_ff);
         end
         ST_CMP, ST_GRP: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skey_ff <= skey_in;
      if (rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `OLIDS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `OLIDS_ASSERT_IMP(a_fin_slot_free, clock, reset, state_ff == ST_FIN, !rsp_valid_ff)
   `OLIDS_ASSERT_NEXT(a_quick_result, clock, reset, accept && !search_go, rsp_valid_ff)
   `OLIDS_ASSERT_IMP(a_found_in_range, clock, reset,
      rsp_valid_ff && (rsp_ff.found_position != '0),
      (rsp_ff.status == STATUS_OK) && (ECNT_W'(rsp_ff.found_position) < rsp_ff.entry_count))

endmodule

FILE: design/olids_cell.sv
module olids_cell
   import olids_pkg::*;
(
   input  logic                 clock,
   input  olids_cmd_type        cmd,
   input  logic [IDX_W-1:0]     cell_index,
   input  logic [KEY_BITS-1:0]  new_key,
   input  logic [DATA_BITS-1:0] new_data,
   input  logic [KEY_BITS-1:0]  left_key,
   input  logic [DATA_BITS-1:0] left_data,
   input  logic [KEY_BITS-1:0]  right_key,
   input  logic [DATA_BITS-1:0] right_data,
   input  logic [KEY_BITS-1:0]  search_key,
   output logic [KEY_BITS-1:0]  key,
   output logic [DATA_BITS-1:0] data,
   output logic                 match
);

   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 match_ff, match_in;
   logic [CNT_W-1:0]     idx_c;

   assign idx_c = CNT_W'(cell_index);

   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      if (cmd.load_en) begin
         unique case (cmd.mode)
            MODE_APPEND, MODE_INSERT: begin
               if (idx_c == cmd.pos) begin
                  key_in  = new_key;
                  data_in = new_data;
               end else if ((idx_c > cmd.pos) && (idx_c <= cmd.count)) begin
                  // make room: take the lower neighbor
                  key_in  = left_key;
                  data_in = left_data;
               end
            end
            MODE_DELETE: begin
               if ((idx_c >= cmd.pos) && ((idx_c + CNT_W'(1)) < cmd.count)) begin
                  // close the gap: take the upper neighbor
                  key_in  = right_key;
                  data_in = right_data;
               end
            end
            MODE_SEARCH: begin
            end
         endcase
      end
   end

   // only entries below the count take part in a search
   assign match_in = (key_ff == search_key) && (idx_c < cmd.count);

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign key   = key_ff;
   assign data  = data_ff;
   assign match = match_ff;

endmodule

FILE: design/olids_prio.sv
module olids_prio
   import olids_pkg::*;
(
   input  logic             clock,
   input  logic [DEPTH-1:0] match_vec,
   output olids_find_type   find
);

   logic [PRIO_PAD_W-1:0]  padded;
   logic [PRIO_GROUPS-1:0] grp_hit_ff, grp_hit_in;
   logic [PRIO_SUB_W-1:0]  grp_idx_ff [PRIO_GROUPS];
   logic [PRIO_SUB_W-1:0]  grp_idx_in [PRIO_GROUPS];
   logic [PRIO_FULL_W-1:0] full_idx;

   assign padded = PRIO_PAD_W'(match_vec);

   // first level: lowest hit inside each group
   always_comb begin
      for (int g = 0; g < PRIO_GROUPS; g++) begin
         grp_hit_in[g] = |padded[g*PRIO_GROUP +: PRIO_GROUP];
         grp_idx_in[g] = '0;
         for (int j = PRIO_GROUP - 1; j >= 0; j--) begin
            if (padded[g*PRIO_GROUP + j]) begin
               grp_idx_in[g] = PRIO_SUB_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_hit_ff <= grp_hit_in;
      grp_idx_ff <= grp_idx_in;
   end

   // second level: lowest group with a hit
   always_comb begin
      full_idx = '0;
      for (int g = PRIO_GROUPS - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            full_idx = PRIO_FULL_W'(g * PRIO_GROUP) + PRIO_FULL_W'(grp_idx_ff[g]);
         end
      end
      find.hit = |grp_hit_ff;
      find.idx = IDX_W'(full_idx);
   end

endmodule
